// File: rtl/core/sts_pkg.sv
package sts_pkg;

  // default width of time stamps
  localparam int TIME_BITS_DEF = 48;

  localparam int ID_BITS   = 32;
  localparam int AGE_BITS  = 32;
  localparam int CNT_BITS  = 32;
  localparam int CFG_BITS  = 32;
  localparam int CIDX_BITS = 8;

  localparam logic [CFG_BITS-1:0] SWITCH_AFTER_RST = 32'd1000000;
  localparam logic [CFG_BITS-1:0] FORGET_AFTER_RST = 32'd5000000;

  // configuration register indexes
  localparam logic [CIDX_BITS-1:0] CFG_SWITCH_AFTER = 8'd0;
  localparam logic [CIDX_BITS-1:0] CFG_FORGET_AFTER = 8'd1;

  // action codes
  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_EXPIRE  = 1'b1;

  typedef enum logic [2:0] {
    OUT_FIRST    = 3'd0,
    OUT_UPDATED  = 3'd1,
    OUT_STALE    = 3'd2,
    OUT_REJECTED = 3'd3,
    OUT_SWITCHED = 3'd4,
    OUT_KEPT     = 3'd5,
    OUT_DROPPED  = 3'd6
  } outcome_t;

  // counter controls from decision logic
  typedef struct packed {
    logic bump_switch;
    logic bump_reject;
  } cnt_ctl_t;

endpackage

// File: rtl/core/sts_in_reg.sv
module sts_in_reg
  import sts_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [ID_BITS-1:0]   in_trk_id,
  input  logic [TIME_BITS-1:0] in_stamp_us,
  input  logic                 in_is_lost,
  input  logic [AGE_BITS-1:0]  in_seen_age_us,
  input  logic [TIME_BITS-1:0] in_now_us,
  input  logic                 down_ready,
  output logic                 s1_valid,
  output logic                 s1_action,
  output logic [ID_BITS-1:0]   s1_trk_id,
  output logic [TIME_BITS-1:0] s1_stamp_us,
  output logic                 s1_is_lost,
  output logic [AGE_BITS-1:0]  s1_seen_age_us,
  output logic [TIME_BITS-1:0] s1_now_us
);

  logic                 valid_r;
  logic                 action_r;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] stamp_r;
  logic                 lost_r;
  logic [AGE_BITS-1:0]  age_r;
  logic [TIME_BITS-1:0] now_r;

  // full and not draining this cycle
  assign in_stall = valid_r && !down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      action_r <= in_action;
      id_r     <= in_trk_id;
      stamp_r  <= in_stamp_us;
      lost_r   <= in_is_lost;
      age_r    <= in_seen_age_us;
      now_r    <= in_now_us;
    end
  end

  assign s1_valid       = valid_r;
  assign s1_action      = action_r;
  assign s1_trk_id      = id_r;
  assign s1_stamp_us    = stamp_r;
  assign s1_is_lost     = lost_r;
  assign s1_seen_age_us = age_r;
  assign s1_now_us      = now_r;

endmodule

// File: rtl/core/sts_decide.sv
module sts_decide
  import sts_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 action,
  input  logic [ID_BITS-1:0]   trk_id,
  input  logic [TIME_BITS-1:0] stamp_us,
  input  logic                 is_lost,
  input  logic [AGE_BITS-1:0]  seen_age_us,
  input  logic [TIME_BITS-1:0] now_us,
  input  logic                 holding,
  input  logic [ID_BITS-1:0]   kept_id,
  input  logic [TIME_BITS-1:0] kept_stamp,
  input  logic [AGE_BITS-1:0]  kept_age,
  input  logic                 kept_lost,
  input  logic [TIME_BITS-1:0] choice_stamp,
  input  logic [CFG_BITS-1:0]  switch_after,
  input  logic [CFG_BITS-1:0]  forget_after,
  output logic                 holding_nxt,
  output logic [ID_BITS-1:0]   kept_id_nxt,
  output logic [TIME_BITS-1:0] kept_stamp_nxt,
  output logic [AGE_BITS-1:0]  kept_age_nxt,
  output logic                 kept_lost_nxt,
  output logic [TIME_BITS-1:0] choice_stamp_nxt,
  output outcome_t             outcome,
  output cnt_ctl_t             cnt_ctl
);

  localparam int HW = TIME_BITS + 1;
  localparam int CW = TIME_BITS + 2;

  logic [TIME_BITS-1:0] t_sel;
  logic [TIME_BITS-1:0] gap;
  logic [HW-1:0]        hold_span;
  logic [CW-1:0]        hold_span_w;
  logic [CW-1:0]        cand_age_w;
  logic                 age_lt;
  logic                 age_gt;
  logic                 near_choice;
  logic                 gap_over;
  logic                 sel_open;
  logic                 prefer;
  logic                 expire_hit;

  // held age at the time of interest; unsaturated, one bit wider
  assign t_sel       = (action == ACT_EXPIRE) ? now_us : stamp_us;
  assign gap         = (t_sel > kept_stamp) ? (t_sel - kept_stamp) : '0;
  assign hold_span   = {1'b0, gap} + HW'(kept_age);
  assign hold_span_w = {1'b0, hold_span};
  assign cand_age_w  = CW'(seen_age_us);

  // ages apart by more than the 1 us tie
  assign age_lt = (cand_age_w + CW'(1)) < hold_span_w;
  assign age_gt = (hold_span_w + CW'(1)) < cand_age_w;

  assign near_choice = (stamp_us == choice_stamp)
                    || ({1'b0, stamp_us} == ({1'b0, choice_stamp} + HW'(1)))
                    || ({1'b0, choice_stamp} == ({1'b0, stamp_us} + HW'(1)));
  assign gap_over = (stamp_us > kept_stamp) && (gap > TIME_BITS'(switch_after));
  assign sel_open = kept_lost || near_choice || gap_over;

  always_comb begin
    if (is_lost != kept_lost) begin
      prefer = kept_lost;
    end else if (age_lt) begin
      prefer = 1'b1;
    end else if (age_gt) begin
      prefer = 1'b0;
    end else begin
      prefer = trk_id < kept_id;
    end
  end

  assign expire_hit = holding && (hold_span > HW'(forget_after));

  always_comb begin
    holding_nxt      = holding;
    kept_id_nxt      = kept_id;
    kept_stamp_nxt   = kept_stamp;
    kept_age_nxt     = kept_age;
    kept_lost_nxt    = kept_lost;
    choice_stamp_nxt = choice_stamp;
    outcome          = OUT_KEPT;
    cnt_ctl          = '0;
    if (action == ACT_OBSERVE) begin
      if (!holding || (trk_id != kept_id && sel_open && prefer)) begin
        holding_nxt      = 1'b1;
        kept_id_nxt      = trk_id;
        kept_stamp_nxt   = stamp_us;
        kept_age_nxt     = seen_age_us;
        kept_lost_nxt    = is_lost;
        choice_stamp_nxt = stamp_us;
        outcome          = holding ? OUT_SWITCHED : OUT_FIRST;
        cnt_ctl.bump_switch = holding;
      end else if (trk_id == kept_id) begin
        if (stamp_us < kept_stamp) begin
          outcome = OUT_STALE;
        end else begin
          // same track: selection stamp stays
          kept_stamp_nxt = stamp_us;
          kept_age_nxt   = seen_age_us;
          kept_lost_nxt  = is_lost;
          outcome        = OUT_UPDATED;
        end
      end else begin
        outcome             = OUT_REJECTED;
        cnt_ctl.bump_reject = 1'b1;
      end
    end else if (expire_hit) begin
      holding_nxt = 1'b0;
      outcome     = OUT_DROPPED;
    end
  end

endmodule

// File: rtl/core/sticky_target_track_selector.sv
// Sticky target track selector.
// Path: a word moves from the input register through the decision logic to the
//   result register when that slot is free; the held-track registers close a loop.
// Throughput: one word per cycle while out_stall is low.
// Reset (rst_n low, synchronous): no target held, counters zero, thresholds to
//   1 s switch and 5 s forget.
module sticky_target_track_selector
  import sts_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CIDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [ID_BITS-1:0]   in_trk_id,
  input  logic [TIME_BITS-1:0] in_stamp_us,
  input  logic                 in_is_lost,
  input  logic [AGE_BITS-1:0]  in_seen_age_us,
  input  logic [TIME_BITS-1:0] in_now_us,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_target_valid,
  output logic [ID_BITS-1:0]   out_held_id,
  output logic [TIME_BITS-1:0] out_held_stamp_us,
  output logic                 out_held_lost,
  output logic [2:0]           out_outcome,
  output logic [CNT_BITS-1:0]  out_switches,
  output logic [CNT_BITS-1:0]  out_rejections
);

  // thresholds
  logic [CFG_BITS-1:0] switch_after_r;
  logic [CFG_BITS-1:0] forget_after_r;

  // held target
  logic                 holding_r;
  logic [ID_BITS-1:0]   kept_id_r;
  logic [TIME_BITS-1:0] kept_stamp_r;
  logic [AGE_BITS-1:0]  kept_age_r;
  logic                 kept_lost_r;
  logic [TIME_BITS-1:0] choice_stamp_r;
  logic [CNT_BITS-1:0]  switch_total_r;
  logic [CNT_BITS-1:0]  reject_total_r;

  logic                 holding_nxt;
  logic [ID_BITS-1:0]   kept_id_nxt;
  logic [TIME_BITS-1:0] kept_stamp_nxt;
  logic [AGE_BITS-1:0]  kept_age_nxt;
  logic                 kept_lost_nxt;
  logic [TIME_BITS-1:0] choice_stamp_nxt;
  logic [CNT_BITS-1:0]  switch_total_nxt;
  logic [CNT_BITS-1:0]  reject_total_nxt;
  outcome_t             outcome;
  cnt_ctl_t             cnt_ctl;

  // input register outputs
  logic                 s1_valid;
  logic                 s1_action;
  logic [ID_BITS-1:0]   s1_trk_id;
  logic [TIME_BITS-1:0] s1_stamp_us;
  logic                 s1_is_lost;
  logic [AGE_BITS-1:0]  s1_seen_age_us;
  logic [TIME_BITS-1:0] s1_now_us;

  // result register
  logic                 out_valid_r;
  logic                 target_valid_r;
  logic [ID_BITS-1:0]   held_id_r;
  logic [TIME_BITS-1:0] held_stamp_r;
  logic                 held_lost_r;
  logic [2:0]           outcome_r;

  logic res_ready;
  logic advance;

  // result slot free or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;
  assign advance   = s1_valid && res_ready;

  //--------------------------------------------------------------------------
  // Config: always ready, writes outside the list are dropped
  //--------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_after_r <= SWITCH_AFTER_RST;
      forget_after_r <= FORGET_AFTER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SWITCH_AFTER: switch_after_r <= cfg_data;
        CFG_FORGET_AFTER: forget_after_r <= cfg_data;
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Input register
  //--------------------------------------------------------------------------
  sts_in_reg #(
    .TIME_BITS (TIME_BITS)
  ) u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_trk_id      (in_trk_id),
    .in_stamp_us    (in_stamp_us),
    .in_is_lost     (in_is_lost),
    .in_seen_age_us (in_seen_age_us),
    .in_now_us      (in_now_us),
    .down_ready     (res_ready),
    .s1_valid       (s1_valid),
    .s1_action      (s1_action),
    .s1_trk_id      (s1_trk_id),
    .s1_stamp_us    (s1_stamp_us),
    .s1_is_lost     (s1_is_lost),
    .s1_seen_age_us (s1_seen_age_us),
    .s1_now_us      (s1_now_us)
  );

  //--------------------------------------------------------------------------
  // Decision: one pass of compares and adds against the held target
  //--------------------------------------------------------------------------
  sts_decide #(
    .TIME_BITS (TIME_BITS)
  ) u_decide (
    .action           (s1_action),
    .trk_id           (s1_trk_id),
    .stamp_us         (s1_stamp_us),
    .is_lost          (s1_is_lost),
    .seen_age_us      (s1_seen_age_us),
    .now_us           (s1_now_us),
    .holding          (holding_r),
    .kept_id          (kept_id_r),
    .kept_stamp       (kept_stamp_r),
    .kept_age         (kept_age_r),
    .kept_lost        (kept_lost_r),
    .choice_stamp     (choice_stamp_r),
    .switch_after     (switch_after_r),
    .forget_after     (forget_after_r),
    .holding_nxt      (holding_nxt),
    .kept_id_nxt      (kept_id_nxt),
    .kept_stamp_nxt   (kept_stamp_nxt),
    .kept_age_nxt     (kept_age_nxt),
    .kept_lost_nxt    (kept_lost_nxt),
    .choice_stamp_nxt (choice_stamp_nxt),
    .outcome          (outcome),
    .cnt_ctl          (cnt_ctl)
  );

  // saturating counters
  assign switch_total_nxt = (cnt_ctl.bump_switch && switch_total_r != '1)
                            ? switch_total_r + CNT_BITS'(1) : switch_total_r;
  assign reject_total_nxt = (cnt_ctl.bump_reject && reject_total_r != '1)
                            ? reject_total_r + CNT_BITS'(1) : reject_total_r;

  //--------------------------------------------------------------------------
  // Held-target state, updated as each word moves into the result register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r      <= 1'b0;
      kept_id_r      <= '0;
      kept_stamp_r   <= '0;
      kept_age_r     <= '0;
      kept_lost_r    <= 1'b0;
      choice_stamp_r <= '0;
      switch_total_r <= '0;
      reject_total_r <= '0;
    end else if (advance) begin
      holding_r      <= holding_nxt;
      kept_id_r      <= kept_id_nxt;
      kept_stamp_r   <= kept_stamp_nxt;
      kept_age_r     <= kept_age_nxt;
      kept_lost_r    <= kept_lost_nxt;
      choice_stamp_r <= choice_stamp_nxt;
      switch_total_r <= switch_total_nxt;
      reject_total_r <= reject_total_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // Result register; held fields read as zero with no target
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      target_valid_r <= holding_nxt;
      held_id_r      <= holding_nxt ? kept_id_nxt : '0;
      held_stamp_r   <= holding_nxt ? kept_stamp_nxt : '0;
      held_lost_r    <= holding_nxt && kept_lost_nxt;
      outcome_r      <= outcome;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target_valid  = target_valid_r;
  assign out_held_id       = held_id_r;
  assign out_held_stamp_us = held_stamp_r;
  assign out_held_lost     = held_lost_r;
  assign out_outcome       = outcome_r;
  // counters settle with the word that last left, so they match its result
  assign out_switches      = switch_total_r;
  assign out_rejections    = reject_total_r;

endmodule
